FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the hill2 queue, keys and back files.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, check the consequence in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hill2_pkg.sv
// Shared types, constants and modulo helper for the 2x2 Hill cipher block.
// No dependencies; every hill2 module refers to it by scoped names.
package hill2_pkg;

    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 5;
    localparam int unsigned PROD_W    = 2 * LETTER_W;
    localparam int unsigned SUM_W     = PROD_W + 1;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 3'd4;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                final_letter;
    } hill2_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                out_last;
        logic                key_error;
    } hill2_out_t;

    typedef struct packed {
        logic [LETTER_W-1:0] p1;
        logic [LETTER_W-1:0] p2;
        logic                fin;
    } hill2_pair_t;

    typedef struct packed {
        logic        valid;
        hill2_pair_t pair;
    } hill2_push_t;

    typedef struct packed {
        logic [3:0][LETTER_W-1:0] m;
        logic                     err;
    } hill2_matrix_t;

    typedef enum logic [2:0] {
        RB_IDLE,
        RB_PROD,
        RB_DET,
        RB_INV,
        RB_SCALE,
        RB_STORE
    } hill2_rb_state_t;

    // Residue modulo 26 of an 11-bit value: reciprocal estimate that is never
    // above the true quotient, then one correcting subtract.
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
        logic [19:0]      est;
        logic [6:0]       q;
        logic [SUM_W-1:0] r;
        est = 20'(x) * 20'd315;
        q   = est[19:13];
        r   = x - SUM_W'(q) * SUM_W'(MODULUS);
        if (r >= SUM_W'(MODULUS))
        begin
            r = r - SUM_W'(MODULUS);
        end
        return r[LETTER_W-1:0];
    endfunction

endpackage

FILE: rtl/core/hill_cipher_2x2_mod26.sv
// Top level of the 2x2 Hill cipher block over letter indices modulo 26.
// Depends on hill2_pkg, hill2_front, hill2_queue, hill2_keys and hill2_back.

// Letters 0..25 arrive one word per cycle, unless stalled, on src and are paired in
// arrival order; each pair (p1, p2) gives two result words on the res channel,
// row 0 of matrix * (p1, p2) first, then row 1, each reduced modulo 26. A final
// letter without a partner is paired with 23 ('x') and out_last marks the second
// word of the pair holding the final letter. With decrypt_mode set the matrix
// is the modular inverse of the key; if the key determinant has no inverse,
// 25 stands in for the determinant inverse and key_error is raised on every
// result word. Sustained rate, with no stall on either side: one letter accepted
// per cycle and, on average, one result word per cycle; a padded lone letter
// occupies the output stage as long as a full pair. The word completing a pair
// passes the queue, the product register and the output register before its
// first result. Any write to a key register starts a rebuild of the inverse key
// through a dedicated multiply and modulo datapath, during which src_stall is
// held high; configuration writes themselves are taken on every cycle and must
// be made while the block is idle. The front part pairs letters, a two-entry
// queue decouples it from the back part, and the back part's output register
// lets a new letter be taken while a finished word still waits on res_stall.
module hill_cipher_2x2_mod26 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             src_valid,
    output logic                             src_stall,
    input  hill2_pkg::hill2_in_t             src_word,
    output logic                             res_valid,
    input  logic                             res_stall,
    output hill2_pkg::hill2_out_t            res_word,
    input  logic                             cfg_we,
    input  logic [hill2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hill2_pkg::CFG_DAT_W-1:0]  cfg_data
);

    hill2_pkg::hill2_push_t   push;
    hill2_pkg::hill2_pair_t   q_pair;
    hill2_pkg::hill2_matrix_t matrix;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_take;
    logic                     busy;

    // Pair letters; hold the src channel while the queue is full or the
    // inverse key is being rebuilt
    hill2_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push)
    );

    hill2_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_pair  (q_pair),
        .pop_take  (q_take)
    );

    // Key, mode and inverse key; selects the matrix in force
    hill2_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix),
        .busy      (busy)
    );

    hill2_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pair    (q_pair),
        .q_take    (q_take),
        .matrix    (matrix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

FILE: rtl/core/hill2_front.sv
// Front part: accepts letter words, pairs them and pads a lone final letter.
// Depends on hill2_pkg.
module hill2_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  hill2_pkg::hill2_in_t  src_word,
    input  logic                  q_full,
    input  logic                  busy,
    output hill2_pkg::hill2_push_t push
);

    logic                          held_valid_reg, held_valid_next;
    logic [hill2_pkg::LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                          accept;

    assign src_stall = q_full | busy;
    assign accept    = src_valid & ~src_stall;

    always_comb
    begin
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        push.valid       = 1'b0;
        push.pair.p1     = held_letter_reg;
        push.pair.p2     = src_word.letter;
        push.pair.fin    = src_word.final_letter;
        if (accept)
        begin
            if (held_valid_reg)
            begin
                // complete the pair with the held letter
                push.valid       = 1'b1;
                held_valid_next  = 1'b0;
                held_letter_next = '0;
            end
            else if (src_word.final_letter)
            begin
                // pad a lone final letter
                push.valid   = 1'b1;
                push.pair.p1 = src_word.letter;
                push.pair.p2 = hill2_pkg::PAD_LETTER;
            end
            else
            begin
                held_valid_next  = 1'b1;
                held_letter_next = src_word.letter;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

endmodule

FILE: rtl/core/hill2_queue.sv
// Short queue of letter pairs between the front and back parts.
// Depends on hill2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hill2_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hill2_pkg::hill2_push_t push,
    output logic                   full,
    output logic                   pop_valid,
    output hill2_pkg::hill2_pair_t pop_pair,
    input  logic                   pop_take
);

    localparam logic [hill2_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        hill2_pkg::QUEUE_PTR_W'(hill2_pkg::QUEUE_DEPTH - 1);
    localparam logic [hill2_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        hill2_pkg::QUEUE_CNT_W'(hill2_pkg::QUEUE_DEPTH);

    hill2_pkg::hill2_pair_t entry_reg [hill2_pkg::QUEUE_DEPTH];
    logic [hill2_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hill2_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hill2_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_pair  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop_take & pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + hill2_pkg::QUEUE_CNT_W'(push.valid)
                               - hill2_pkg::QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_CLK(a_queue_no_overflow, !(push.valid && full), "pair pushed into a full queue")

endmodule

FILE: rtl/core/hill2_keys.sv
// Key and mode registers, plus the sequencer that rebuilds the inverse key.
// Depends on hill2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hill2_keys (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hill2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hill2_pkg::CFG_DAT_W-1:0]      cfg_data,
    output hill2_pkg::hill2_matrix_t             matrix,
    output logic                                 busy
);

    localparam int unsigned LW = hill2_pkg::LETTER_W;
    localparam int unsigned PW = hill2_pkg::PROD_W;
    localparam int unsigned SW = hill2_pkg::SUM_W;

    function automatic logic [LW-1:0] red26(input logic [LW-1:0] v);
        return (v >= hill2_pkg::MODULUS) ? v - hill2_pkg::MODULUS : v;
    endfunction

    function automatic logic [LW-1:0] neg26(input logic [LW-1:0] v);
        return (v == '0) ? '0 : hill2_pkg::MODULUS - v;
    endfunction

    // Multiplicative inverse modulo 26, zero where none exists
    function automatic logic [LW-1:0] inv26(input logic [LW-1:0] v);
        logic [LW-1:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    logic [3:0][LW-1:0] key_reg;
    logic               decrypt_reg;
    logic [3:0][LW-1:0] inv_reg;
    logic               missing_reg;

    hill2_pkg::hill2_rb_state_t state_reg, state_next;

    logic [3:0][LW-1:0] red_reg;
    logic [PW-1:0]      ad_reg, bc_reg;
    logic [LW-1:0]      det_reg;
    logic [LW-1:0]      dinv_reg;
    logic [3:0][PW-1:0] sp_reg;
    logic [3:0][LW-1:0] red_now;
    logic [LW-1:0]      dinv_raw;
    logic               key_write;

    assign key_write = cfg_we && (cfg_index inside {hill2_pkg::CFG_KEY_TL,
        hill2_pkg::CFG_KEY_TR, hill2_pkg::CFG_KEY_BL, hill2_pkg::CFG_KEY_BR});

    assign busy     = (state_reg != hill2_pkg::RB_IDLE);
    assign dinv_raw = inv26(det_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            red_now[i] = red26(key_reg[i]);
        end
    end

    always_comb
    begin
        matrix.m   = decrypt_reg ? inv_reg : key_reg;
        matrix.err = decrypt_reg & missing_reg;
    end

    // Register writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= {5'd1, 5'd0, 5'd0, 5'd1};
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hill2_pkg::CFG_KEY_TL:  key_reg[0]  <= cfg_data;
                hill2_pkg::CFG_KEY_TR:  key_reg[1]  <= cfg_data;
                hill2_pkg::CFG_KEY_BL:  key_reg[2]  <= cfg_data;
                hill2_pkg::CFG_KEY_BR:  key_reg[3]  <= cfg_data;
                hill2_pkg::CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hill2_pkg::RB_IDLE:  state_next = hill2_pkg::RB_IDLE;
            hill2_pkg::RB_PROD:  state_next = hill2_pkg::RB_DET;
            hill2_pkg::RB_DET:   state_next = hill2_pkg::RB_INV;
            hill2_pkg::RB_INV:   state_next = hill2_pkg::RB_SCALE;
            hill2_pkg::RB_SCALE: state_next = hill2_pkg::RB_STORE;
            hill2_pkg::RB_STORE: state_next = hill2_pkg::RB_IDLE;
            default:             state_next = hill2_pkg::RB_IDLE;
        endcase
        // restart on any key write, also mid-rebuild
        if (key_write)
        begin
            state_next = hill2_pkg::RB_PROD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hill2_pkg::RB_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Rebuild datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hill2_pkg::RB_PROD:
            begin
                red_reg <= red_now;
                ad_reg  <= PW'(red_now[0]) * PW'(red_now[3]);
                bc_reg  <= PW'(red_now[1]) * PW'(red_now[2]);
            end
            hill2_pkg::RB_DET:
            begin
                det_reg <= hill2_pkg::mod26(SW'(ad_reg) + SW'(676) - SW'(bc_reg));
            end
            hill2_pkg::RB_INV:
            begin
                dinv_reg <= (dinv_raw == '0) ? hill2_pkg::MODULUS - 5'd1 : dinv_raw;
            end
            hill2_pkg::RB_SCALE:
            begin
                sp_reg[0] <= PW'(red_reg[3]) * PW'(dinv_reg);
                sp_reg[1] <= PW'(neg26(red_reg[1])) * PW'(dinv_reg);
                sp_reg[2] <= PW'(neg26(red_reg[2])) * PW'(dinv_reg);
                sp_reg[3] <= PW'(red_reg[0]) * PW'(dinv_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg     <= {5'd1, 5'd0, 5'd0, 5'd1};
            missing_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == hill2_pkg::RB_INV)
            begin
                missing_reg <= (dinv_raw == '0);
            end
            if (state_reg == hill2_pkg::RB_STORE)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    inv_reg[i] <= hill2_pkg::mod26(SW'(sp_reg[i]));
                end
            end
        end
    end

    `ASSERT_NEXT(a_keys_rebuild_on_write, key_write, state_reg == hill2_pkg::RB_PROD, "key write did not start a rebuild")

endmodule

FILE: rtl/core/hill2_back.sv
// Back part: multiplies each queued pair by the active matrix and delivers
// the two result words in order. Depends on hill2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hill2_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  hill2_pkg::hill2_pair_t   q_pair,
    output logic                     q_take,
    input  hill2_pkg::hill2_matrix_t matrix,
    output logic                     res_valid,
    input  logic                     res_stall,
    output hill2_pkg::hill2_out_t    res_word
);

    localparam int unsigned LW = hill2_pkg::LETTER_W;
    localparam int unsigned PW = hill2_pkg::PROD_W;
    localparam int unsigned SW = hill2_pkg::SUM_W;

    // Product stage
    logic               s1_valid_reg;
    logic [3:0][PW-1:0] prod_reg;
    logic               s1_fin_reg, s1_err_reg;

    // Output stage: both result letters, delivered row 0 then row 1
    logic               s2_valid_reg;
    logic               phase_reg;
    logic [1:0][LW-1:0] row_reg;
    logic               s2_fin_reg, s2_err_reg;

    logic out_fire, s2_free, s2_load, s1_free;

    assign out_fire = s2_valid_reg & ~res_stall;
    assign s2_free  = ~s2_valid_reg | (out_fire & phase_reg);
    assign s2_load  = s1_valid_reg & s2_free;
    assign s1_free  = ~s1_valid_reg | s2_load;
    assign q_take   = q_valid & s1_free;

    assign res_valid           = s2_valid_reg;
    assign res_word.out_letter = phase_reg ? row_reg[1] : row_reg[0];
    assign res_word.out_last   = phase_reg & s2_fin_reg;
    assign res_word.key_error  = s2_err_reg;

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            prod_reg[0] <= PW'(matrix.m[0]) * PW'(q_pair.p1);
            prod_reg[1] <= PW'(matrix.m[1]) * PW'(q_pair.p2);
            prod_reg[2] <= PW'(matrix.m[2]) * PW'(q_pair.p1);
            prod_reg[3] <= PW'(matrix.m[3]) * PW'(q_pair.p2);
            s1_fin_reg  <= q_pair.fin;
            s1_err_reg  <= matrix.err;
        end
        if (s2_load)
        begin
            row_reg[0] <= hill2_pkg::mod26(SW'(prod_reg[0]) + SW'(prod_reg[1]));
            row_reg[1] <= hill2_pkg::mod26(SW'(prod_reg[2]) + SW'(prod_reg[3]));
            s2_fin_reg <= s1_fin_reg;
            s2_err_reg <= s1_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= q_take;
            end
            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
                phase_reg    <= 1'b0;
            end
            else if (out_fire)
            begin
                // advance to row 1, or drop the pair after row 1
                s2_valid_reg <= ~phase_reg;
                phase_reg    <= ~phase_reg;
            end
        end
    end

    `ASSERT_CLK(a_back_phase_held, !phase_reg || s2_valid_reg, "second row pending with no pair held")
    `ASSERT_NEXT(a_back_pair_whole, out_fire && !phase_reg, s2_valid_reg && phase_reg, "pair split after its first word")

endmodule

FILE: dv/tb_hill_cipher_2x2_mod26.sv
// Self-checking testbench for hill_cipher_2x2_mod26.
// Runs a directed table, then random letter streams.
// Depends on hill2_pkg and the block under rtl/core; predicts result words unless a row types them out.
module tb_hill_cipher_2x2_mod26;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LETTERS          = 26;
    localparam int SETTLE_CYCLES    = 8;       // covers the inverse rebuild
    localparam int CYCLE_LIMIT      = 250000;
    localparam int KEY_SETTINGS     = 15;
    localparam int LETTERS_PER_KEY  = 84;

    // Indexes past the register list; writes there must change nothing
    localparam logic [hill2_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = hill2_pkg::CFG_DECRYPT + 3'd1;
    localparam logic [hill2_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One row of the directed table: either a register write or a letter word,
    // optionally with its two result words written out by hand.
    typedef struct packed {
        row_kind_t                         kind;
        logic [hill2_pkg::CFG_IDX_W-1:0]   index;
        logic [hill2_pkg::CFG_DAT_W-1:0]   data;
        hill2_pkg::hill2_in_t              word;
        logic                              typed;
        hill2_pkg::hill2_out_t             first;
        hill2_pkg::hill2_out_t             second;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  src_valid = 1'b0;
    logic                  src_stall;
    hill2_pkg::hill2_in_t  src_word  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    hill2_pkg::hill2_out_t res_word;
    logic                            cfg_we    = 1'b0;
    logic [hill2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hill2_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    // Cipher state as the block should hold it
    logic [hill2_pkg::LETTER_W-1:0] key_m [4];
    int                             inv_m [4];
    logic                           no_inverse;
    logic                           decrypting;
    logic [hill2_pkg::LETTER_W-1:0] held;
    logic                           holding;

    hill2_pkg::hill2_out_t expected_words [$];
    stim_row_t             stim_rows [$];

    int send_idle_pct  = 26;
    int recv_idle_pct  = 51;
    int mismatches     = 0;
    int words_checked  = 0;
    int letters_sent   = 0;
    int cycle_count    = 0;

    hill_cipher_2x2_mod26 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Recompute the inverse key after any key write. A determinant with no
    // inverse modulo 26 takes 25 in place of its inverse and flags the key.
    function automatic void derive_inverse();
        int a, b, c, d, det, dinv;
        a = int'(key_m[0]) % LETTERS;
        b = int'(key_m[1]) % LETTERS;
        c = int'(key_m[2]) % LETTERS;
        d = int'(key_m[3]) % LETTERS;
        det = (a * d + (LETTERS - (b * c) % LETTERS) % LETTERS) % LETTERS;
        dinv = 0;
        for (int x = LETTERS - 1; x >= 1; x--)
        begin
            if ((det * x) % LETTERS == 1)
            begin
                dinv = x;
            end
        end
        no_inverse = (dinv == 0);
        if (no_inverse)
        begin
            dinv = LETTERS - 1;
        end
        inv_m[0] = (d * dinv) % LETTERS;
        inv_m[1] = (((LETTERS - b) % LETTERS) * dinv) % LETTERS;
        inv_m[2] = (((LETTERS - c) % LETTERS) * dinv) % LETTERS;
        inv_m[3] = (a * dinv) % LETTERS;
    endfunction

    function automatic void apply_register(input logic [hill2_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [hill2_pkg::CFG_DAT_W-1:0] value);
        case (idx)
            hill2_pkg::CFG_KEY_TL:  begin key_m[0] = value; derive_inverse(); end
            hill2_pkg::CFG_KEY_TR:  begin key_m[1] = value; derive_inverse(); end
            hill2_pkg::CFG_KEY_BL:  begin key_m[2] = value; derive_inverse(); end
            hill2_pkg::CFG_KEY_BR:  begin key_m[3] = value; derive_inverse(); end
            hill2_pkg::CFG_DECRYPT: decrypting = value[0];
            default:                ;
        endcase
    endfunction

    // Pair one letter word; return the number of result words it completes.
    function automatic int cipher_step(input hill2_pkg::hill2_in_t w,
                                       output hill2_pkg::hill2_out_t first,
                                       output hill2_pkg::hill2_out_t second);
        int   p1, p2;
        int   m [4];
        logic err;
        first  = '0;
        second = '0;
        if (holding)
        begin
            p1 = int'(held);
            p2 = int'(w.letter);
        end
        else if (w.final_letter)
        begin
            p1 = int'(w.letter);
            p2 = int'(hill2_pkg::PAD_LETTER);
        end
        else
        begin
            held    = w.letter;
            holding = 1'b1;
            return 0;
        end
        holding = 1'b0;
        held    = '0;
        if (decrypting)
        begin
            m   = inv_m;
            err = no_inverse;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                m[i] = int'(key_m[i]);
            end
            err = 1'b0;
        end
        first.out_letter  = hill2_pkg::LETTER_W'((m[0] * p1 + m[1] * p2) % LETTERS);
        first.key_error   = err;
        second.out_letter = hill2_pkg::LETTER_W'((m[2] * p1 + m[3] * p2) % LETTERS);
        second.out_last   = w.final_letter;
        second.key_error  = err;
        return 2;
    endfunction

    function automatic stim_row_t word_row(input logic [hill2_pkg::LETTER_W-1:0] letter,
                                           input logic fin);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word.letter = letter;
        r.word.final_letter = fin;
        return r;
    endfunction

    // Letter word whose two results are written out: out_last follows fin on the second
    function automatic stim_row_t typed_row(input logic [hill2_pkg::LETTER_W-1:0] letter,
                                            input logic fin,
                                            input logic [hill2_pkg::LETTER_W-1:0] first_letter,
                                            input logic [hill2_pkg::LETTER_W-1:0] second_letter,
                                            input logic err);
        stim_row_t r;
        r = word_row(letter, fin);
        r.typed = 1'b1;
        r.first.out_letter  = first_letter;
        r.first.key_error   = err;
        r.second.out_letter = second_letter;
        r.second.out_last   = fin;
        r.second.key_error  = err;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [hill2_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [hill2_pkg::CFG_DAT_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.data  = value;
        return r;
    endfunction

    // Offer one letter word after a random gap and hold it until taken. Junk
    // goes on the payload while valid is low; the word is frozen once offered.
    task automatic send_word(input hill2_pkg::hill2_in_t w, input logic typed,
                             input hill2_pkg::hill2_out_t want_first,
                             input hill2_pkg::hill2_out_t want_second);
        hill2_pkg::hill2_out_t first, second;
        int                    produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
            src_word  <= hill2_pkg::hill2_in_t'(6'($urandom));
        end
        @(negedge clk);
        src_valid <= 1'b1;
        src_word  <= w;
        do @(posedge clk); while (src_stall == 1'b1);
        produced = cipher_step(w, first, second);
        if (produced != 0)
        begin
            expected_words.push_back(typed ? want_first : first);
            expected_words.push_back(typed ? want_second : second);
        end
        letters_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [hill2_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [hill2_pkg::CFG_DAT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        apply_register(idx, value);
    endtask

    // Receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        res_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each taken result word with the oldest expectation, field by field
    always @(posedge clk)
    begin
        hill2_pkg::hill2_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected: expected none, actual %p",
                         $time, res_word);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (res_word.out_letter !== want.out_letter)
                begin
                    $display("%0t: out_letter expected %0d actual %0d",
                             $time, want.out_letter, res_word.out_letter);
                    mismatches++;
                end
                if (res_word.out_last !== want.out_last)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.out_last, res_word.out_last);
                    mismatches++;
                end
                if (res_word.key_error !== want.key_error)
                begin
                    $display("%0t: key_error expected %0b actual %0b",
                             $time, want.key_error, res_word.key_error);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d result words outstanding",
                     $time, expected_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [hill2_pkg::LETTER_W-1:0]  key_pick [4];
        logic [hill2_pkg::CFG_DAT_W-1:0] mode_data;
        logic [hill2_pkg::LETTER_W-1:0]  letter;
        logic                            fin;
        logic                            noisy;
        hill2_pkg::hill2_in_t            rnd_word;
        int                              det;
        int                              msg_len;
        int                              epoch_letters;

        // Predictor starts from the reset key: identity, encrypt
        key_m[0] = 5'd1;
        key_m[1] = 5'd0;
        key_m[2] = 5'd0;
        key_m[3] = 5'd1;
        inv_m[0] = 1;
        inv_m[1] = 0;
        inv_m[2] = 0;
        inv_m[3] = 1;
        no_inverse = 1'b0;
        decrypting = 1'b0;
        held       = '0;
        holding    = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Reset key first, then singular and zero keys in
        // decrypt, a proper key, mode and key changes with a letter held, a
        // lone final letter, writes past the register list and out of range
        // values in both letters and keys.
        stim_rows.push_back(word_row(5'd0, 1'b0));
        stim_rows.push_back(typed_row(5'd25, 1'b0, 5'd0, 5'd25, 1'b0));
        stim_rows.push_back(typed_row(5'd31, 1'b1, 5'd5, hill2_pkg::PAD_LETTER, 1'b0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TL, 5'd25));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TR, 5'd25));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BL, 5'd25));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BR, 5'd25));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_DECRYPT, 5'd1));
        stim_rows.push_back(word_row(5'd1, 1'b0));
        stim_rows.push_back(word_row(5'd0, 1'b1));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TL, 5'd0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TR, 5'd0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BL, 5'd0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BR, 5'd0));
        stim_rows.push_back(word_row(5'd7, 1'b0));
        stim_rows.push_back(typed_row(5'd9, 1'b1, 5'd0, 5'd0, 1'b1));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TL, 5'd3));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TR, 5'd3));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BL, 5'd2));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BR, 5'd5));
        stim_rows.push_back(word_row(5'd25, 1'b0));
        stim_rows.push_back(word_row(5'd12, 1'b0));
        stim_rows.push_back(word_row(5'd4, 1'b0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_DECRYPT, 5'd0));
        stim_rows.push_back(word_row(5'd11, 1'b1));
        stim_rows.push_back(word_row(5'd2, 1'b0));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TR, 5'd31));
        stim_rows.push_back(word_row(5'd30, 1'b0));
        stim_rows.push_back(word_row(5'd5, 1'b1));
        stim_rows.push_back(cfg_row(CFG_SPARE_LO, 5'd31));
        stim_rows.push_back(cfg_row(CFG_SPARE_HI, 5'd31));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_DECRYPT, 5'b11110));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_TL, 5'd31));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BL, 5'd31));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_KEY_BR, 5'd31));
        stim_rows.push_back(word_row(5'd31, 1'b0));
        stim_rows.push_back(word_row(5'd31, 1'b1));
        stim_rows.push_back(cfg_row(hill2_pkg::CFG_DECRYPT, 5'b11111));
        stim_rows.push_back(word_row(5'd26, 1'b1));

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_CFG)
            begin
                write_register(stim_rows[r].index, stim_rows[r].data);
            end
            else
            begin
                send_word(stim_rows[r].word, stim_rows[r].typed,
                          stim_rows[r].first, stim_rows[r].second);
            end
        end

        // Random part: one key setting per epoch, idle mix advancing by thirds
        for (int epoch = 0; epoch < KEY_SETTINGS; epoch++)
        begin
            case (epoch * 3 / KEY_SETTINGS)
                0:       begin send_idle_pct = 26; recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            case (epoch % 6)
                0, 5:
                begin
                    // Pick a key whose determinant is a unit modulo 26
                    do
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            key_pick[i] = hill2_pkg::LETTER_W'($urandom_range(25));
                        end
                        det = (int'(key_pick[0]) * int'(key_pick[3]) + LETTERS * LETTERS
                               - int'(key_pick[1]) * int'(key_pick[2])) % LETTERS;
                    end
                    while (det % 2 == 0 || det % 13 == 0);
                    mode_data = (epoch % 6 == 0) ? 5'd1 : 5'd0;
                end
                1:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        key_pick[i] = hill2_pkg::LETTER_W'($urandom_range(31));
                    end
                    mode_data = hill2_pkg::CFG_DAT_W'($urandom);
                end
                2:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        key_pick[i] = 5'd25;
                    end
                    mode_data = 5'd1;
                end
                3:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        key_pick[i] = 5'd0;
                    end
                    mode_data = 5'd0;
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        key_pick[i] = 5'd31;
                    end
                    mode_data = 5'b11111;
                end
            endcase
            write_register(hill2_pkg::CFG_KEY_TL, key_pick[0]);
            write_register(hill2_pkg::CFG_KEY_TR, key_pick[1]);
            write_register(hill2_pkg::CFG_KEY_BL, key_pick[2]);
            write_register(hill2_pkg::CFG_KEY_BR, key_pick[3]);
            write_register(hill2_pkg::CFG_DECRYPT, mode_data);

            // Mostly well-formed messages ending on a final letter; one in ten
            // carries random final marks to break the pairing.
            epoch_letters = 0;
            while (epoch_letters < LETTERS_PER_KEY)
            begin
                msg_len = $urandom_range(12, 1);
                noisy   = ($urandom_range(9) == 0);
                for (int i = 0; i < msg_len; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        letter = hill2_pkg::LETTER_W'($urandom_range(31, 26));
                    end
                    else
                    begin
                        letter = hill2_pkg::LETTER_W'($urandom_range(25));
                    end
                    fin = noisy ? 1'($urandom_range(1)) : (i == msg_len - 1);
                    rnd_word.letter       = letter;
                    rnd_word.final_letter = fin;
                    send_word(rnd_word, 1'b0, '0, '0);
                end
                epoch_letters += msg_len;
            end
        end

        // Drain and let any stray word show itself
        wait_idle();

        $display("Sent %0d letter words and checked %0d result words over %0d directed rows",
                 letters_sent, words_checked, stim_rows.size());
        $display("and %0d random key settings, under three idle mixes.", KEY_SETTINGS);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: hill_cipher_2x2_mod26.f
+incdir+rtl/core
rtl/core/hill2_pkg.sv
rtl/core/hill2_front.sv
rtl/core/hill2_queue.sv
rtl/core/hill2_keys.sv
rtl/core/hill2_back.sv
rtl/core/hill_cipher_2x2_mod26.sv
dv/tb_hill_cipher_2x2_mod26.sv
